FILE: design/block_bitmap_allocator_hinted_unit_macros.svh
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_HINTED_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_HINTED_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBAH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbah check failed");

// Next-cycle implication, checked outside reset.
`define BBAH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbah check failed");

`endif

FILE: design/bbah_pkg.sv
// ----------------------------------------------------------------------------
// bbah_pkg
// Shared constants, types and helpers of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bbah_pkg;

	localparam int MaxGroups     = 16;
	localparam int MaxBpg        = 8192;
	localparam int WordBits      = 64;
	localparam int WordsPerGroup = MaxBpg / WordBits;
	localparam int BitmapWords   = MaxGroups * WordsPerGroup;
	localparam int AddrW         = $clog2(BitmapWords);
	localparam int GrpW          = $clog2(MaxGroups);
	localparam int WordW         = $clog2(WordsPerGroup);
	localparam int BitW          = $clog2(WordBits);

	localparam int BpgW   = 14;
	localparam int GcW    = 5;
	localparam int IpgW   = 14;
	localparam int BlkW   = 17;
	localparam int HintW  = 18;
	localparam int TotW   = 18;
	localparam int TdataW = 40;

	typedef enum logic [1:0] {
		CFG_BPG = 2'd0,
		CFG_GC  = 2'd1,
		CFG_IPG = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_BADFREE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_RD,
		S_EV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [BpgW-1:0] bpg;
		logic [GcW-1:0]  ng;
		logic [IpgW-1:0] ipg;
	} eff_cfg_t;

	typedef struct packed {
		status_t         status;
		logic [BlkW-1:0] blk;
		logic [TotW-1:0] free_total;
	} res_t;

	function automatic logic [BitW-1:0] lowest_set(input logic [WordBits-1:0] v);
		logic [BitW-1:0] r;
		r = '0;
		for (int i = WordBits - 1; i >= 0; i--) begin
			if (v[i]) r = BitW'(i);
		end
		return r;
	endfunction

endpackage

FILE: design/bbah_ram.sv
// ----------------------------------------------------------------------------
// bbah_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bbah_ram #(
	parameter int Width = 64,
	parameter int Depth = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/bbah_ctrl.sv
// ----------------------------------------------------------------------------
// bbah_ctrl
// Request sequencer: group division, bitmap word scan, read-modify-write of
// the bitmap memory, and the used counters.
// ----------------------------------------------------------------------------
module bbah_ctrl import bbah_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  eff_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_action,
	input  logic [BlkW-1:0]     in_blk,
	input  logic [HintW-1:0]    in_hint,
	output logic                ram_we,
	output logic [AddrW-1:0]    ram_waddr,
	output logic [WordBits-1:0] ram_wdata,
	output logic                ram_re,
	output logic [AddrW-1:0]    ram_raddr,
	input  logic [WordBits-1:0] ram_rdata,
	output logic                res_valid,
	output res_t                res,
	input  logic                res_ready
);

	state_t state_q, state_d;

	logic [AddrW-1:0]  clr_q;
	logic              op_free_q;
	logic [HintW-1:0]  rem_q;
	logic [GcW-1:0]    cnt_q;
	logic              has_pref_q;
	logic [GrpW-1:0]   pref_q;
	logic [GrpW-1:0]   grp_q;
	logic              pref_phase_q;
	logic [WordW-1:0]  word_q;
	logic [BitW-1:0]   bit_q;
	status_t           status_q;
	logic [BlkW-1:0]   got_q;
	logic [TotW-1:0]   used_q;
	logic [BpgW-1:0]   grp_used_q [MaxGroups];

	logic [HintW-1:0]    divisor;
	logic [BpgW:0]       left;
	logic [WordBits-1:0] mask;
	logic [WordBits-1:0] freebits;
	logic [BitW-1:0]     pick;
	logic [GcW-1:0]      cand0;
	logic [GcW-1:0]      cand;
	logic [TotW:0]       got_full;
	logic [TotW:0]       cap;

	assign divisor  = op_free_q ? HintW'(cfg.bpg) : HintW'(cfg.ipg);
	assign left     = {1'b0, cfg.bpg} - (BpgW+1)'({word_q, {BitW{1'b0}}});
	assign mask     = (left >= (BpgW+1)'(WordBits)) ? '1
	                  : ((WordBits'(1) << left[BitW-1:0]) - WordBits'(1));
	assign freebits = ~ram_rdata & mask;
	assign pick     = lowest_set(freebits);
	assign got_full = (TotW+1)'(grp_q) * (TotW+1)'(cfg.bpg) + (TotW+1)'({word_q, pick});
	assign cap      = (TotW+1)'(cfg.ng) * (TotW+1)'(cfg.bpg);

	// Next group to scan once the current one is full; the preferred group
	// was tried first and is skipped in the in-order pass.
	assign cand0 = pref_phase_q ? '0 : GcW'(grp_q) + GcW'(1);
	assign cand  = (has_pref_q && cand0 == GcW'(pref_q)) ? cand0 + GcW'(1) : cand0;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = {grp_q, word_q};
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = {grp_q, word_q};
		res_valid = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AddrW'(BitmapWords - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_action && in_hint == '0) state_d = S_RD;
					else state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == cfg.ng) begin
					state_d = op_free_q ? S_DONE : S_RD;
				end else if (rem_q < divisor) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				if (op_free_q) begin
					if (ram_rdata[bit_q]) begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata & ~(WordBits'(1) << bit_q);
					end
					state_d = S_DONE;
				end else if (freebits != '0) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (WordBits'(1) << pick);
					state_d   = S_DONE;
				end else if (left > (BpgW+1)'(WordBits)) begin
					state_d = S_RD;
				end else if (cand >= cfg.ng) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			used_q  <= '0;
			for (int i = 0; i < MaxGroups; i++) grp_used_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + AddrW'(1);
			if (state_q == S_EV && ram_we) begin
				if (op_free_q) begin
					if (used_q != '0) used_q <= used_q - TotW'(1);
					if (grp_used_q[grp_q] != '0) grp_used_q[grp_q] <= grp_used_q[grp_q] - BpgW'(1);
				end else begin
					if (used_q != '1) used_q <= used_q + TotW'(1);
					if (grp_used_q[grp_q] < BpgW'(MaxBpg))
						grp_used_q[grp_q] <= grp_used_q[grp_q] + BpgW'(1);
				end
			end
		end
	end

	// Request datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_free_q    <= in_action;
				cnt_q        <= '0;
				rem_q        <= in_action ? HintW'(in_blk) : in_hint - HintW'(1);
				has_pref_q   <= 1'b0;
				pref_phase_q <= 1'b0;
				grp_q        <= '0;
				word_q       <= '0;
				status_q     <= STAT_OK;
				got_q        <= '0;
			end
			S_DIV: begin
				if (cnt_q == cfg.ng) begin
					if (op_free_q) status_q <= STAT_BADFREE;
				end else if (rem_q >= divisor) begin
					rem_q <= rem_q - divisor;
					cnt_q <= cnt_q + GcW'(1);
				end else begin
					grp_q <= cnt_q[GrpW-1:0];
					if (op_free_q) begin
						word_q <= rem_q[BitW +: WordW];
						bit_q  <= rem_q[BitW-1:0];
					end else begin
						has_pref_q   <= 1'b1;
						pref_q       <= cnt_q[GrpW-1:0];
						pref_phase_q <= 1'b1;
					end
				end
			end
			S_EV: begin
				if (op_free_q) begin
					if (!ram_rdata[bit_q]) status_q <= STAT_BADFREE;
				end else if (freebits != '0) begin
					got_q <= got_full[BlkW-1:0];
				end else if (left > (BpgW+1)'(WordBits)) begin
					word_q <= word_q + WordW'(1);
				end else if (cand >= cfg.ng) begin
					status_q <= STAT_NOSPACE;
				end else begin
					word_q       <= '0;
					grp_q        <= cand[GrpW-1:0];
					pref_phase_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.status     = status_q;
	assign res.blk        = got_q;
	assign res.free_total = (cap > (TotW+1)'(used_q)) ? TotW'(cap - (TotW+1)'(used_q)) : '0;

endmodule

FILE: design/block_bitmap_allocator_hinted_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_hinted_unit
// Hinted block allocator over a grouped usage bitmap held in one RAM.
// ----------------------------------------------------------------------------
// After reset the unit clears every word of the bitmap RAM and takes
// no beat meanwhile; configuration writes are taken at any time. A free runs
// the group division, then a read-modify-write of one bitmap word. An allocate
// runs the division for the hint group when a hint is given, then reads and
// checks each 64-bit bitmap word examined in turn on the single read port,
// over up to 16 groups of 8192 blocks. One request is in work at a time, and a
// result beat may wait in the output register while the next request is taken.
module block_bitmap_allocator_hinted_unit import bbah_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [TdataW-1:0] s_tdata,   // block_number, owner_inode, zero pad
	input  logic              s_tuser,   // action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TdataW-1:0] m_tdata,   // allocated_block, free_total, zero pad
	output logic [1:0]        m_tuser,   // status
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [BpgW-1:0]   cfg_data
);

	logic [BpgW-1:0] bpg_q;
	logic [GcW-1:0]  gc_q;
	logic [IpgW-1:0] ipg_q;
	eff_cfg_t        eff;
	logic [BpgW-1:0] bpg_round;

	logic                ram_we, ram_re;
	logic [AddrW-1:0]    ram_waddr, ram_raddr;
	logic [WordBits-1:0] ram_wdata, ram_rdata;
	logic                res_valid, res_ready;
	res_t                res, res_q;
	logic                m_tvalid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpg_q <= BpgW'(8192);
			gc_q  <= GcW'(16);
			ipg_q <= IpgW'(2048);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BPG: bpg_q <= cfg_data;
				CFG_GC:  gc_q  <= cfg_data[GcW-1:0];
				CFG_IPG: ipg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign bpg_round = {bpg_q[BpgW-1:3], 3'b000};
	always_comb begin
		eff.bpg = bpg_round;
		if (bpg_round == '0) eff.bpg = BpgW'(8);
		else if (bpg_round > BpgW'(MaxBpg)) eff.bpg = BpgW'(MaxBpg);
		eff.ng = gc_q;
		if (gc_q == '0) eff.ng = GcW'(1);
		else if (gc_q > GcW'(MaxGroups)) eff.ng = GcW'(MaxGroups);
		eff.ipg = (ipg_q == '0) ? IpgW'(1) : ipg_q;
	end

	bbah_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (eff),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_blk    (s_tdata[BlkW-1:0]),
		.in_hint   (s_tdata[BlkW +: HintW]),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	bbah_ram #(
		.Width (WordBits),
		.Depth (BitmapWords)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {(TdataW-BlkW-TotW)'(0), res_q.free_total, res_q.blk};

endmodule

FILE: design/bbah_checker.sv
// ----------------------------------------------------------------------------
// bbah_checker
// Port-level checks on the result stream of the block allocator.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_hinted_unit_macros.svh"

module bbah_checker import bbah_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [TdataW-1:0] m_tdata,
	input logic [1:0]        m_tuser
);

	`BBAH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`BBAH_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3)
	`BBAH_ASSERT_NOW(a_fail_no_block, m_tvalid && m_tuser != STAT_OK, m_tdata[BlkW-1:0] == '0)
	`BBAH_ASSERT_NOW(a_free_bound, m_tvalid, m_tdata[BlkW +: TotW] <= TotW'(MaxGroups * MaxBpg))

endmodule

bind block_bitmap_allocator_hinted_unit bbah_checker u_bbah_checker (.*);
